// File: rtl/core/irs_pkg.sv
// irs_pkg: shared types and codes for the indexed record stack
// used by irs_cell, indexed_record_stack and irs_check; no dependencies
`default_nettype none

package irs_pkg;

    // fixed widths of the port fields
    localparam int OUT_BITS  = 32;
    localparam int RANK_BITS = 5;

    // action codes carried by an input word
    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_EDIT   = 3'd4,
        ACT_SEARCH = 3'd5
    } act_t;

    // result status codes
    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_BADPOS  = 3'd3,
        STAT_NOMATCH = 3'd4
    } status_t;

    // search field selector codes
    localparam logic [1:0] SEL_BRAND  = 2'd0;
    localparam logic [1:0] SEL_SIZE   = 2'd1;
    localparam logic [1:0] SEL_COLOUR = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fsm_t;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        COP_HOLD,
        COP_WRITE,
        COP_INSERT,
        COP_REMOVE,
        COP_ROTATE
    } cell_op_t;

endpackage

`default_nettype wire

// File: rtl/core/irs_cell.sv
// irs_cell: one slot of the record chain, holds one record
// depends on irs_pkg for the cell command type
`default_nettype none

module irs_cell
    import irs_pkg::*;
#(
    parameter int FIELD_BITS = 32,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  wire logic                    aclk,
    input  wire cell_op_t                op,
    input  wire logic [CW-1:0]           tgt,
    input  wire logic [3*FIELD_BITS-1:0] load_rec,
    input  wire logic [3*FIELD_BITS-1:0] lower_rec,
    input  wire logic [3*FIELD_BITS-1:0] upper_rec,
    output logic      [3*FIELD_BITS-1:0] rec
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [3*FIELD_BITS-1:0] rec_reg;
    logic [3*FIELD_BITS-1:0] rec_next;

    // local decision from own slot number against the target slot
    always_comb begin
        rec_next = rec_reg;
        case (op)
            COP_WRITE: begin
                if (IDX == tgt) rec_next = load_rec;
            end
            COP_INSERT: begin
                if (IDX == tgt) begin
                    rec_next = load_rec;
                end else if (IDX > tgt) begin
                    rec_next = lower_rec;
                end
            end
            COP_REMOVE: begin
                if (IDX >= tgt) rec_next = upper_rec;
            end
            COP_ROTATE: rec_next = lower_rec;
            default:    rec_next = rec_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

// File: rtl/core/indexed_record_stack.sv
// indexed_record_stack: top level, sequencer and chain of record cells
// depends on irs_pkg and irs_cell
`default_nettype none

// Bounded stack of STACK_DEPTH three-field records held in a chain of cells,
// slot 0 at the bottom. Push, insert, remove and edit finish in the cycle the
// word is accepted: each cell loads, shifts from its neighbor or holds, and one
// result word follows. Pop of an empty stack answers the same way. Pop of a
// non-empty stack and search rotate the whole chain once past a comparator on the
// top cell, one slot per cycle while no pending match is held up in front of the
// result register: accept, STACK_DEPTH rotation steps, final result. A rotation
// step that must pass on a pending match waits while the result port still holds
// the result register, as does the final word. Actions 6 and 7 give no result.
// Search returns matches top to bottom with their rank from the top and marks
// the final one with last; no match gives a single no-match word. The result
// register lets a new word be accepted in the cycle the previous result leaves.
module indexed_record_stack
    import irs_pkg::*;
#(
    parameter int STACK_DEPTH = 20,
    parameter int FIELD_BITS  = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [4:0]  s_position,
    input  wire logic [31:0] s_brand_code,
    input  wire logic [31:0] s_size_code,
    input  wire logic [31:0] s_colour_code,
    input  wire logic [1:0]  s_search_field,
    input  wire logic [31:0] s_search_key,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_out_brand,
    output logic [31:0]      m_out_size,
    output logic [31:0]      m_out_colour,
    output logic [4:0]       m_match_rank,
    output logic             m_last
);

    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int IW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int KW   = (FIELD_BITS < OUT_BITS) ? FIELD_BITS : OUT_BITS;
    localparam int RKW  = (CW + 1 > RANK_BITS) ? CW + 1 : RANK_BITS;
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;
    localparam int RECW = 3 * FIELD_BITS;

    // sequencer and bookkeeping registers
    fsm_t                  state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         k_reg, k_next;
    act_t                  op_reg, op_next;
    logic [1:0]            sel_reg, sel_next;
    logic [FIELD_BITS-1:0] key_reg, key_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [RECW-1:0]       pend_rec_reg, pend_rec_next;
    logic [4:0]            pend_rank_reg, pend_rank_next;

    // result register
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [RECW-1:0]       m_rec_reg;
    logic [4:0]            m_rank_reg;
    logic                  m_last_reg;

    logic                  out_load;
    status_t               out_status;
    logic [RECW-1:0]       out_rec;
    logic [4:0]            out_rank;
    logic                  out_last;

    // chain control
    cell_op_t              cell_op;
    logic [CW-1:0]         cell_tgt;
    logic [RECW-1:0]       in_rec;
    logic [RECW-1:0]       cell_rec [STACK_DEPTH];
    logic [RECW-1:0]       top_rec;

    logic                  slot_free;
    logic                  s_acc;
    logic                  full;
    logic                  empty;
    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic                  start_scan;
    logic [RKW-1:0]        scan_sum;
    logic [RKW-1:0]        rank_full;
    logic                  in_range;
    logic                  fmatch;
    logic                  hit;
    logic                  need_emit;
    logic                  advance;
    logic                  k_last;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign s_acc     = s_valid && s_ready;

    assign full    = (count_reg == CW'(STACK_DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMPW'(s_position);
    assign cnt_ext = CMPW'(count_reg);

    assign start_scan = ((act_t'(s_action) == ACT_POP) && !empty)
                        || (act_t'(s_action) == ACT_SEARCH);

    // record fields kept in FIELD_BITS bits
    assign in_rec = {FIELD_BITS'(s_colour_code[KW-1:0]),
                     FIELD_BITS'(s_size_code[KW-1:0]),
                     FIELD_BITS'(s_brand_code[KW-1:0])};

    // chain of cells, slot 0 at the bottom, rotation wraps top to bottom
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        localparam int LO = (g == 0) ? STACK_DEPTH - 1 : g - 1;
        localparam int UP = (g == STACK_DEPTH - 1) ? g : g + 1;
        irs_cell #(
            .FIELD_BITS(FIELD_BITS),
            .CW        (CW),
            .INDEX     (g)
        ) u_cell (
            .aclk     (aclk),
            .op       (cell_op),
            .tgt      (cell_tgt),
            .load_rec (in_rec),
            .lower_rec(cell_rec[LO]),
            .upper_rec(cell_rec[UP]),
            .rec      (cell_rec[g])
        );
    end

    assign top_rec = cell_rec[STACK_DEPTH-1];

    // scan step k shows original slot STACK_DEPTH-1-k on the top cell
    assign scan_sum  = RKW'(k_reg) + RKW'(count_reg);
    assign in_range  = (scan_sum >= RKW'(STACK_DEPTH));
    assign rank_full = scan_sum - RKW'(STACK_DEPTH) + RKW'(1);
    assign k_last    = (k_reg == IW'(STACK_DEPTH - 1));

    // field compare against the key; unused selector never matches
    always_comb begin
        case (sel_reg)
            SEL_BRAND:  fmatch = (top_rec[0*FIELD_BITS +: FIELD_BITS] == key_reg);
            SEL_SIZE:   fmatch = (top_rec[1*FIELD_BITS +: FIELD_BITS] == key_reg);
            SEL_COLOUR: fmatch = (top_rec[2*FIELD_BITS +: FIELD_BITS] == key_reg);
            default:    fmatch = 1'b0;
        endcase
    end

    assign hit = in_range && ((op_reg == ACT_POP) ? (scan_sum == RKW'(STACK_DEPTH))
                                                  : fmatch);
    assign need_emit = hit && pend_valid_reg;
    assign advance   = !need_emit || slot_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc && start_scan) state_next = ST_SCAN;
            ST_SCAN: if (advance && k_last) state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and result words
    always_comb begin
        cell_op         = COP_HOLD;
        cell_tgt        = count_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        pend_rank_next  = pend_rank_reg;
        out_load        = 1'b0;
        out_status      = STAT_OK;
        out_rec         = '0;
        out_rank        = '0;
        out_last        = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    op_next         = act_t'(s_action);
                    sel_next        = s_search_field;
                    key_next        = FIELD_BITS'(s_search_key[KW-1:0]);
                    k_next          = '0;
                    pend_valid_next = 1'b0;
                    unique case (act_t'(s_action))
                        ACT_PUSH: begin
                            out_load = 1'b1;
                            if (full) begin
                                out_status = STAT_FULL;
                            end else begin
                                cell_op    = COP_WRITE;
                                cell_tgt   = count_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                out_load   = 1'b1;
                                out_status = STAT_EMPTY;
                            end
                        end
                        ACT_INSERT: begin
                            out_load = 1'b1;
                            if (full) begin
                                out_status = STAT_FULL;
                            end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                                out_status = STAT_BADPOS;
                            end else begin
                                cell_op    = COP_INSERT;
                                cell_tgt   = CW'(pos_ext - CMPW'(1));
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_REMOVE: begin
                            out_load = 1'b1;
                            if (empty) begin
                                out_status = STAT_EMPTY;
                            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                out_status = STAT_BADPOS;
                            end else begin
                                cell_op    = COP_REMOVE;
                                cell_tgt   = CW'(pos_ext - CMPW'(1));
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ACT_EDIT: begin
                            out_load = 1'b1;
                            if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                out_status = STAT_BADPOS;
                            end else begin
                                cell_op  = COP_WRITE;
                                cell_tgt = CW'(pos_ext - CMPW'(1));
                            end
                        end
                        ACT_SEARCH: ;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    cell_op = COP_ROTATE;
                    k_next  = k_reg + IW'(1);
                    if (need_emit) begin
                        out_load   = 1'b1;
                        out_status = STAT_OK;
                        out_rec    = pend_rec_reg;
                        out_rank   = pend_rank_reg;
                        out_last   = 1'b0;
                    end
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_rec_next   = top_rec;
                        pend_rank_next  = (op_reg == ACT_POP) ? 5'd0 : rank_full[4:0];
                    end
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg) begin
                        out_status = STAT_OK;
                        out_rec    = pend_rec_reg;
                        out_rank   = pend_rank_reg;
                    end else begin
                        out_status = STAT_NOMATCH;
                    end
                    if (op_reg == ACT_POP) count_next = count_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        op_reg        <= op_next;
        sel_reg       <= sel_next;
        key_reg       <= key_next;
        pend_rec_reg  <= pend_rec_next;
        pend_rank_reg <= pend_rank_next;
        if (out_load) begin
            m_status_reg <= out_status;
            m_rec_reg    <= out_rec;
            m_rank_reg   <= out_rank;
            m_last_reg   <= out_last;
        end
    end

    // result port
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_brand  = OUT_BITS'(m_rec_reg[0*FIELD_BITS +: KW]);
    assign m_out_size   = OUT_BITS'(m_rec_reg[1*FIELD_BITS +: KW]);
    assign m_out_colour = OUT_BITS'(m_rec_reg[2*FIELD_BITS +: KW]);
    assign m_match_rank = m_rank_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/irs_check.sv
// irs_check: port-level checks for indexed_record_stack, bound to the top level
// depends on irs_pkg for status codes
`default_nettype none

module irs_check
    import irs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_out_brand,
    input wire logic [31:0] m_out_size,
    input wire logic [31:0] m_out_colour,
    input wire logic [4:0]  m_match_rank,
    input wire logic        m_last
);

    // a stalled result word holds its status, last flag, rank and brand field
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last)
            && $stable(m_match_rank) && $stable(m_out_brand))
        else $error("result word changed while stalled");

    // every non-ok status is a single, final word
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_last)
        else $error("error status without last");

    // error and no-match words carry no record and no rank
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_match_rank == 5'd0
            && m_out_brand == 32'd0 && m_out_size == 32'd0 && m_out_colour == 32'd0)
        else $error("error status with record data");

    // a ranked word carries ok status, as a search hit does
    a_rank_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_match_rank != 5'd0 |-> m_status == STAT_OK)
        else $error("match rank on a non-ok word");

endmodule

bind indexed_record_stack irs_check u_irs_check (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_out_brand (m_out_brand),
    .m_out_size  (m_out_size),
    .m_out_colour(m_out_colour),
    .m_match_rank(m_match_rank),
    .m_last      (m_last)
);

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for indexed_record_stack: directed and random stack words, predicted
// and checked by a scoreboard class; depends on irs_pkg and indexed_record_stack

module testbench;
    import irs_pkg::*;

    localparam int DEPTH = 20;

    // action codes with no meaning, and the selector that matches nothing
    localparam logic [2:0] ACT_NOP_A = 3'd6;
    localparam logic [2:0] ACT_NOP_B = 3'd7;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    typedef struct packed {
        logic [31:0] brand;
        logic [31:0] size;
        logic [31:0] colour;
    } record_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  position;
        record_t     rec;
        logic [1:0]  field_sel;
        logic [31:0] key;
    } word_t;

    typedef struct packed {
        logic [2:0]  status;
        record_t     rec;
        logic [4:0]  rank;
        logic        last;
    } result_t;

    // mirror of the record stack plus the queue of results still owed
    class stack_scoreboard;
        record_t slots [DEPTH];
        int      used;
        result_t owed_results [$];
        int      errors;
        int      words;
        int      results;
        int      match_hits;
        int      full_hits;
        int      peak;

        function void owe(logic [2:0] st, record_t r, logic [4:0] rk, logic lst);
            result_t e;
            e.status = st;
            e.rec    = r;
            e.rank   = rk;
            e.last   = lst;
            owed_results.insert(owed_results.size(), e);
        endfunction

        // update the mirror for one accepted word and queue its results
        function void note_word(word_t w);
            record_t     none;
            result_t     tail;
            logic [31:0] field;
            int          pos;
            int          hits;
            none = '0;
            pos  = w.position;
            hits = 0;
            words++;
            case (w.action)
                ACT_PUSH: begin
                    if (used >= DEPTH) begin
                        full_hits++;
                        owe(STAT_FULL, none, 5'd0, 1'b1);
                    end else begin
                        slots[used] = w.rec;
                        used++;
                        owe(STAT_OK, none, 5'd0, 1'b1);
                    end
                end
                ACT_POP: begin
                    if (used == 0) begin
                        owe(STAT_EMPTY, none, 5'd0, 1'b1);
                    end else begin
                        used--;
                        owe(STAT_OK, slots[used], 5'd0, 1'b1);
                    end
                end
                ACT_INSERT: begin
                    // full is checked before the position
                    if (used >= DEPTH) begin
                        full_hits++;
                        owe(STAT_FULL, none, 5'd0, 1'b1);
                    end else if (pos < 1 || pos > used + 1) begin
                        owe(STAT_BADPOS, none, 5'd0, 1'b1);
                    end else begin
                        for (int i = used; i > pos - 1; i--) slots[i] = slots[i - 1];
                        slots[pos - 1] = w.rec;
                        used++;
                        owe(STAT_OK, none, 5'd0, 1'b1);
                    end
                end
                ACT_REMOVE: begin
                    // empty is checked before the position
                    if (used == 0) begin
                        owe(STAT_EMPTY, none, 5'd0, 1'b1);
                    end else if (pos < 1 || pos > used) begin
                        owe(STAT_BADPOS, none, 5'd0, 1'b1);
                    end else begin
                        for (int i = pos - 1; i + 1 < used; i++) slots[i] = slots[i + 1];
                        used--;
                        slots[used] = '0;
                        owe(STAT_OK, none, 5'd0, 1'b1);
                    end
                end
                ACT_EDIT: begin
                    // an empty stack gives bad position here, not empty
                    if (pos < 1 || pos > used) begin
                        owe(STAT_BADPOS, none, 5'd0, 1'b1);
                    end else begin
                        slots[pos - 1] = w.rec;
                        owe(STAT_OK, none, 5'd0, 1'b1);
                    end
                end
                ACT_SEARCH: begin
                    // scan top to bottom, rank counted from the top
                    for (int i = used - 1; i >= 0; i--) begin
                        case (w.field_sel)
                            SEL_BRAND:  field = slots[i].brand;
                            SEL_SIZE:   field = slots[i].size;
                            SEL_COLOUR: field = slots[i].colour;
                            default:    field = 'x;
                        endcase
                        if (w.field_sel != SEL_NONE && field == w.key) begin
                            owe(STAT_OK, slots[i], 5'(used - i), 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        owe(STAT_NOMATCH, none, 5'd0, 1'b1);
                    end else begin
                        tail = owed_results[owed_results.size() - 1];
                        tail.last = 1'b1;
                        owed_results[owed_results.size() - 1] = tail;
                        match_hits += hits;
                    end
                end
                default: ;  // meaningless action: no result, no change
            endcase
            if (used > peak) peak = used;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // compare one result word against the oldest owed result
        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0) begin
                $error("unexpected result word: status %0d", got.status);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            results++;
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_brand", want.rec.brand, got.rec.brand);
            compare_field("out_size", want.rec.size, got.rec.size);
            compare_field("out_colour", want.rec.colour, got.rec.colour);
            compare_field("match_rank", 32'(want.rank), 32'(got.rank));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action       = '0;
    logic [4:0]  s_position     = '0;
    logic [31:0] s_brand_code   = '0;
    logic [31:0] s_size_code    = '0;
    logic [31:0] s_colour_code  = '0;
    logic [1:0]  s_search_field = '0;
    logic [31:0] s_search_key   = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_out_brand;
    logic [31:0] m_out_size;
    logic [31:0] m_out_colour;
    logic [4:0]  m_match_rank;
    logic        m_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    stack_scoreboard sb = new();

    indexed_record_stack #(
        .STACK_DEPTH (DEPTH),
        .FIELD_BITS  (32)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_position     (s_position),
        .s_brand_code   (s_brand_code),
        .s_size_code    (s_size_code),
        .s_colour_code  (s_colour_code),
        .s_search_field (s_search_field),
        .s_search_key   (s_search_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_brand    (m_out_brand),
        .m_out_size     (m_out_size),
        .m_out_colour   (m_out_colour),
        .m_match_rank   (m_match_rank),
        .m_last         (m_last)
    );

    // 20 ns clock
    always #10 aclk = ~aclk;

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watch both handshakes at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result({m_status, m_out_brand, m_out_size, m_out_colour,
                                 m_match_rank, m_last});
            if (s_valid && s_ready)
                sb.note_word({s_action, s_position, s_brand_code, s_size_code,
                              s_colour_code, s_search_field, s_search_key});
        end
    end

    // offer one word, with random idle cycles in front, until it is taken
    task automatic drive_word(input word_t w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= w.action;
        s_position     <= w.position;
        s_brand_code   <= w.rec.brand;
        s_size_code    <= w.rec.size;
        s_colour_code  <= w.rec.colour;
        s_search_field <= w.field_sel;
        s_search_key   <= w.key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off the input until every owed result has arrived
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_results.size() != 0) @(posedge aclk);
    endtask

    function automatic word_t mk(logic [2:0] act, logic [4:0] pos, record_t r,
                                 logic [1:0] sel, logic [31:0] key);
        word_t w;
        w.action    = act;
        w.position  = pos;
        w.rec       = r;
        w.field_sel = sel;
        w.key       = key;
        return w;
    endfunction

    // field values drawn mostly from a small pool so searches hit
    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 9))
            0:             return 32'h0;
            1:             return 32'hFFFF_FFFF;
            2, 3, 4, 5:    return 32'($urandom_range(1, 3));
            default:       return $urandom();
        endcase
    endfunction

    // random word; filling leans toward push and insert to reach full
    function automatic word_t make_word(bit filling);
        word_t   w;
        record_t probe;
        int      roll;
        int      lim;
        w.rec = {pick_code(), pick_code(), pick_code()};
        roll  = $urandom_range(0, 99);
        if (filling) begin
            if (roll < 55)      w.action = ACT_PUSH;
            else if (roll < 80) w.action = ACT_INSERT;
            else if (roll < 88) w.action = ACT_SEARCH;
            else if (roll < 94) w.action = ACT_EDIT;
            else                w.action = ACT_POP;
        end else begin
            if (roll < 18)      w.action = ACT_PUSH;
            else if (roll < 33) w.action = ACT_POP;
            else if (roll < 48) w.action = ACT_INSERT;
            else if (roll < 63) w.action = ACT_REMOVE;
            else if (roll < 73) w.action = ACT_EDIT;
            else if (roll < 95) w.action = ACT_SEARCH;
            else                w.action = $urandom_range(0, 1) ? ACT_NOP_A : ACT_NOP_B;
        end
        // mostly legal positions, sometimes anything the port allows
        lim = (w.action == ACT_INSERT) ? sb.used + 1 : sb.used;
        if ($urandom_range(0, 99) < 85 && lim >= 1)
            w.position = 5'($urandom_range(1, lim));
        else
            w.position = 5'($urandom_range(0, 31));
        w.field_sel = ($urandom_range(0, 9) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
        // key taken from a live entry half the time
        roll = $urandom_range(0, 99);
        if (roll < 50 && sb.used > 0) begin
            probe = sb.slots[$urandom_range(0, sb.used - 1)];
            case (w.field_sel)
                SEL_SIZE:   w.key = probe.size;
                SEL_COLOUR: w.key = probe.colour;
                default:    w.key = probe.brand;
            endcase
        end else if (roll < 75) begin
            w.key = pick_code();
        end else begin
            w.key = $urandom();
        end
        return w;
    endfunction

    // main sequence
    initial begin
        record_t zero_rec;
        record_t ones_rec;
        record_t rec_a;
        record_t rec_b;
        zero_rec = '0;
        ones_rec = '1;
        rec_a    = {32'h1234_5678, 32'h0000_0002, 32'hA5A5_A5A5};
        rec_b    = {32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_5A5A};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, bad positions, field extremes, every action
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_POP,    5'd0,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_REMOVE, 5'd1,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_EDIT,   5'd1,  ones_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_INSERT, 5'd0,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_INSERT, 5'd2,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_PUSH,   5'd0,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_PUSH,   5'd31, ones_rec, SEL_NONE,  32'hFFFF_FFFF));
        drive_word(mk(ACT_INSERT, 5'd1,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_INSERT, 5'd4,  rec_b,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_INSERT, 5'd31, rec_b,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_REMOVE, 5'd0,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_REMOVE, 5'd5,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_EDIT,   5'd5,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_EDIT,   5'd0,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_EDIT,   5'd2,  ones_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_BRAND,  32'hFFFF_FFFF));
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_SIZE,   32'h0));
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_COLOUR, 32'hA5A5_A5A5));
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_NONE,   32'h0));
        drive_word(mk(ACT_NOP_A,  5'd1,  rec_a,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_NOP_B,  5'd1,  rec_b,    SEL_BRAND, 32'h0));
        drive_word(mk(ACT_REMOVE, 5'd2,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_POP,    5'd0,  zero_rec, SEL_BRAND, 32'h0));
        drive_word(mk(ACT_SEARCH, 5'd0,  zero_rec, SEL_BRAND, 32'hDEAD_BEEF));
        drain();

        // random: three idle profiles, each a fill stretch then a mixed stretch
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 28; recv_idle_pct = 80; end
                1:       begin send_idle_pct = 80; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int k = 0; k < 45; k++) begin
                drive_word(make_word(k < 30));
                if (ph == 0 && k == 40) drain();
            end
            drain();
        end

        // let any stray result show up before the verdict
        repeat (2 * DEPTH + 8) @(posedge aclk);
        $display("run covered %0d words and %0d result words: %0d search matches,",
                 sb.words, sb.results, sb.match_hits);
        $display("  %0d full rejections, peak depth %0d of %0d",
                 sb.full_hits, sb.peak, DEPTH);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("[indexed_record_stack] OK");
        end else begin
            $display("[indexed_record_stack] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("[indexed_record_stack] ERROR");
        $finish;
    end

endmodule

// File: indexed_record_stack.f
rtl/core/irs_pkg.sv
rtl/core/irs_cell.sv
rtl/core/indexed_record_stack.sv
rtl/core/irs_check.sv
tb/testbench.sv
